// ----- rtl/pixel_and_cursor_format_converter_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the pixel and cursor format converter
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PIXEL_AND_CURSOR_FORMAT_CONVERTER_ASSERT_SVH
`define PIXEL_AND_CURSOR_FORMAT_CONVERTER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PCFC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define PCFC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PCFC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define PCFC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/pcfc_pkg.sv -----
// ----------------------------------------------------------------------------
// pcfc_pkg
// Operation codes, format codes and shared types of the format converter.
// ----------------------------------------------------------------------------
package pcfc_pkg;

    localparam logic [1:0] OP_PAL_WR  = 2'd0;
    localparam logic [1:0] OP_CONVERT = 2'd1;
    localparam logic [1:0] OP_MONO    = 2'd2;
    localparam logic [1:0] OP_ALPHA   = 2'd3;

    localparam logic [2:0] FMT_1BPP  = 3'd0;
    localparam logic [2:0] FMT_8BPP  = 3'd1;
    localparam logic [2:0] FMT_15BPP = 3'd2;
    localparam logic [2:0] FMT_16BPP = 3'd3;
    localparam logic [2:0] FMT_24BPP = 3'd4;
    localparam logic [2:0] FMT_32BPP = 3'd5;

    localparam logic OUT_RGB  = 1'b0;
    localparam logic OUT_MONO = 1'b1;

    localparam logic CFG_IN_FORMAT  = 1'b0;
    localparam logic CFG_OUT_FORMAT = 1'b1;

    localparam logic [2:0] IN_FORMAT_RESET  = FMT_24BPP;
    localparam logic       OUT_FORMAT_RESET = OUT_RGB;

    localparam logic [23:0] RGB_WHITE    = 24'hffffff;
    localparam logic [31:0] ALPHA_OPAQUE = 32'hff000000;

    typedef logic [23:0] rgb_t;

    // palette write request
    typedef struct packed {
        logic       en;
        logic [7:0] index;
        rgb_t       rgb;
    } pal_wr_t;

    // palette read request
    typedef struct packed {
        logic       en;
        logic [7:0] index;
    } pal_rd_t;

endpackage

// ----- rtl/pixel_and_cursor_format_converter.sv -----
// ----------------------------------------------------------------------------
// pixel_and_cursor_format_converter
// Pixel to RGB / mono conversion with palette and cursor modes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one transaction per pixel or
//   palette write; op selects palette write, convert, mono or alpha cursor.
//   Output channel (out_valid/out_ready) returns colour_out and mask_out,
//   one transaction for every op except palette write, in input order.
//   Configuration channel (cfg_valid/cfg_ready) writes in_format (index 0)
//   or out_format (index 1); write it only while the block is idle.
//   A pixel is registered in the read stage and then in the output register.
//   Throughput: one transaction per cycle unless the output stalls; the
//   palette RAM has a registered read issued at acceptance, and a write is
//   seen by the very next read.
//   Reset: in_format is 24 bpp, out_format RGB, and every palette entry
//   reads as zero until written (valid bits cleared at once, no sweep).
//   Stall: when out_ready is low and the output register is full, the output
//   register and the read stage hold; in_ready drops only when both are full.
// ----------------------------------------------------------------------------
`include "pixel_and_cursor_format_converter_assert.svh"

module pixel_and_cursor_format_converter
    import pcfc_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [2:0]  cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [31:0] pixel_in,
    input  logic [7:0]  palette_index,
    input  logic [7:0]  palette_red,
    input  logic [7:0]  palette_green,
    input  logic [7:0]  palette_blue,
    input  logic        and_bit,
    input  logic        col_odd,
    input  logic        row_odd,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] colour_out,
    output logic        mask_out
);

    logic [2:0]  in_format_reg;
    logic        out_format_reg;

    logic        in_fire;
    logic        s1_move;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [1:0]  s1_op_reg;
    logic [31:0] s1_pixel_reg;
    logic        s1_and_reg;
    logic        s1_same_reg;

    logic        out_valid_reg;
    logic [1:0]  out_op_reg;
    logic [31:0] colour_reg;
    logic        mask_reg;

    pal_wr_t     pal_wr;
    pal_rd_t     pal_rd;
    rgb_t        pal_rgb;
    logic [31:0] conv_colour;
    logic        conv_mask;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_format_reg  <= IN_FORMAT_RESET;
            out_format_reg <= OUT_FORMAT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_IN_FORMAT:  in_format_reg  <= cfg_data;
                CFG_OUT_FORMAT: out_format_reg <= cfg_data[0];
                default:        in_format_reg  <= in_format_reg;
            endcase
        end
    end

    assign s1_move  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_move;
    assign in_fire  = in_valid && in_ready;

    // palette writes retire at acceptance; only pixels enter the read stage
    assign pal_wr.en    = in_fire && (op == OP_PAL_WR);
    assign pal_wr.index = palette_index;
    assign pal_wr.rgb   = {palette_red, palette_green, palette_blue};
    assign pal_rd.en    = in_fire && (op != OP_PAL_WR);
    assign pal_rd.index = pixel_in[7:0];

    pcfc_palette #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_palette (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (pal_wr),
        .rd      (pal_rd),
        .rd_data (pal_rgb)
    );

    assign s1_valid_next = in_ready ? (in_fire && (op != OP_PAL_WR))
                                    : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg    <= op;
            s1_pixel_reg <= pixel_in;
            s1_and_reg   <= and_bit;
            s1_same_reg  <= (col_odd == row_odd);
        end
    end

    pcfc_convert u_convert (
        .in_format  (in_format_reg),
        .out_format (out_format_reg),
        .op         (s1_op_reg),
        .pixel      (s1_pixel_reg),
        .pal_rgb    (pal_rgb),
        .and_bit    (s1_and_reg),
        .same       (s1_same_reg),
        .colour     (conv_colour),
        .mask       (conv_mask)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_valid_reg)
        begin
            out_op_reg <= s1_op_reg;
            colour_reg <= conv_colour;
            mask_reg   <= conv_mask;
        end
    end

    assign out_valid  = out_valid_reg;
    assign colour_out = colour_reg;
    assign mask_out   = mask_reg;

    `PCFC_ASSERT_NXT(a_pixel_enters_stage, clk, rst_n,
        in_fire && (op != OP_PAL_WR), s1_valid_reg, "accepted pixel lost")
    `PCFC_ASSERT_NXT(a_stage_holds, clk, rst_n,
        s1_valid_reg && !s1_move, s1_valid_reg, "read stage dropped while stalled")
    `PCFC_ASSERT_IMP(a_mask_only_mono, clk, rst_n,
        out_valid_reg && mask_reg, out_op_reg == OP_MONO, "mask set outside mono cursor")
    `PCFC_ASSERT_IMP(a_no_palette_result, clk, rst_n,
        out_valid_reg, out_op_reg != OP_PAL_WR, "palette write produced a result")

endmodule

// ----- rtl/pcfc_palette.sv -----
// ----------------------------------------------------------------------------
// pcfc_palette
// Palette RAM with registered read and per-entry valid bits, so
// that never-written entries read as zero after reset.
// ----------------------------------------------------------------------------
module pcfc_palette
    import pcfc_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  pal_wr_t wr,
    input  pal_rd_t rd,
    output rgb_t    rd_data
);

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    rgb_t                     mem [PALETTE_DEPTH];
    logic [PALETTE_DEPTH-1:0] valid_reg;
    rgb_t                     mem_q_reg;
    logic                     hit_reg;
    logic                     wr_in_range;
    logic                     rd_in_range;
    logic [AW-1:0]            wr_addr;
    logic [AW-1:0]            rd_addr;

    assign wr_in_range = {1'b0, wr.index} < 9'(PALETTE_DEPTH);
    assign rd_in_range = {1'b0, rd.index} < 9'(PALETTE_DEPTH);
    assign wr_addr     = wr.index[AW-1:0];
    assign rd_addr     = rd.index[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr.en && wr_in_range)
        begin
            mem[wr_addr] <= wr.rgb;
        end
        if (rd.en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr.en && wr_in_range)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd.en)
            begin
                hit_reg <= rd_in_range && valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = hit_reg ? mem_q_reg : '0;

endmodule

// ----- rtl/pcfc_convert.sv -----
// ----------------------------------------------------------------------------
// pcfc_convert
// Widens one source pixel to RGB and applies the plain, mono-cursor or
// alpha-cursor output rule.
// ----------------------------------------------------------------------------
module pcfc_convert
    import pcfc_pkg::*;
(
    input  logic [2:0]  in_format,
    input  logic        out_format,
    input  logic [1:0]  op,
    input  logic [31:0] pixel,
    input  rgb_t        pal_rgb,
    input  logic        and_bit,
    input  logic        same,
    output logic [31:0] colour,
    output logic        mask
);

    rgb_t rgb;
    logic nz;

    always_comb
    begin
        unique case (in_format)
            FMT_1BPP:  rgb = (pixel != '0) ? RGB_WHITE : '0;
            FMT_8BPP:  rgb = pal_rgb;
            FMT_15BPP: rgb = {pixel[14:10], pixel[14:12], pixel[9:5], pixel[10:8],
                              pixel[4:0], pixel[4:2]};
            FMT_16BPP: rgb = {pixel[15:11], pixel[15:13], pixel[10:5], pixel[10:9],
                              pixel[4:0], pixel[4:2]};
            FMT_24BPP,
            FMT_32BPP: rgb = {pixel[7:0], pixel[15:8], pixel[23:16]};
            default:   rgb = '0;
        endcase
    end

    assign nz = (rgb != '0);

    always_comb
    begin
        colour = '0;
        mask   = 1'b0;
        unique case (op)
            OP_CONVERT:
            begin
                colour = (out_format == OUT_MONO) ? {31'b0, nz} : {8'b0, rgb};
            end
            OP_MONO:
            begin
                if (nz && and_bit)
                begin
                    colour = {31'b0, same};
                    mask   = 1'b1;
                end
                else
                begin
                    colour = {31'b0, nz};
                    mask   = !and_bit;
                end
            end
            OP_ALPHA:
            begin
                if (nz && and_bit)
                begin
                    colour = ALPHA_OPAQUE | {8'b0, (same ? RGB_WHITE : 24'b0)};
                end
                else
                begin
                    colour = {8'b0, rgb} | (and_bit ? 32'b0 : ALPHA_OPAQUE);
                end
            end
            default:
            begin
                colour = '0;
                mask   = 1'b0;
            end
        endcase
    end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pixel and cursor format converter. Drives
// palette writes, conversions and both cursor ops through the input channel,
// predicts every result from a local palette and register copy, and checks
// the output channel in order while both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import pcfc_pkg::*;

    localparam int CLK_HALF          = 4;
    localparam int RESET_CYCLES      = 10;
    localparam int SETTLE_CYCLES     = 4;
    localparam int CYCLE_LIMIT       = 400000;
    localparam int MAX_REPORTS       = 10;
    localparam int ITEMS_PER_SETTING = 75;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] pixel;
        logic [7:0]  pal_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        and_bit;
        logic        col_odd;
        logic        row_odd;
    } pixel_txn_t;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] colour;
        logic        mask;
    } colour_result_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic        cfg_index     = CFG_IN_FORMAT;
    logic [2:0]  cfg_data      = '0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic [1:0]  op            = OP_CONVERT;
    logic [31:0] pixel_in      = '0;
    logic [7:0]  palette_index = '0;
    logic [7:0]  palette_red   = '0;
    logic [7:0]  palette_green = '0;
    logic [7:0]  palette_blue  = '0;
    logic        and_bit       = 1'b0;
    logic        col_odd       = 1'b0;
    logic        row_odd       = 1'b0;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic [31:0] colour_out;
    logic        mask_out;

    // local copy of the converter state
    rgb_t        model_palette [256];
    logic [2:0]  model_in_format  = IN_FORMAT_RESET;
    logic        model_out_format = OUT_FORMAT_RESET;

    colour_result_t expected_results [$];

    int send_idle_pct  = 7;
    int recv_stall_pct = 64;
    int error_count    = 0;
    int result_count   = 0;
    int cycle_count    = 0;
    int op_count [4]   = '{0, 0, 0, 0};

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    pixel_and_cursor_format_converter i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .pixel_in      (pixel_in),
        .palette_index (palette_index),
        .palette_red   (palette_red),
        .palette_green (palette_green),
        .palette_blue  (palette_blue),
        .and_bit       (and_bit),
        .col_odd       (col_odd),
        .row_odd       (row_odd),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .colour_out    (colour_out),
        .mask_out      (mask_out)
    );

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic rgb_t source_to_rgb(input logic [31:0] p);
        case (model_in_format)
            FMT_1BPP:             return (p != '0) ? RGB_WHITE : '0;
            FMT_8BPP:             return model_palette[p[7:0]];
            FMT_15BPP:            return {p[14:10], p[14:12], p[9:5], p[10:8], p[4:0], p[4:2]};
            FMT_16BPP:            return {p[15:11], p[15:13], p[10:5], p[10:9], p[4:0], p[4:2]};
            FMT_24BPP, FMT_32BPP: return {p[7:0], p[15:8], p[23:16]};
            default:              return '0;
        endcase
    endfunction

    // Update the palette copy on a write; otherwise build the result.
    function automatic bit predict_result(input pixel_txn_t t, output colour_result_t r);
        rgb_t rgb;
        logic lit;
        logic same;
        r.op     = t.op;
        r.colour = '0;
        r.mask   = 1'b0;
        if (t.op == OP_PAL_WR)
        begin
            model_palette[t.pal_index] = {t.red, t.green, t.blue};
            return 1'b0;
        end
        rgb  = source_to_rgb(t.pixel);
        lit  = (rgb != '0);
        same = (t.col_odd == t.row_odd);
        case (t.op)
            OP_CONVERT:
                r.colour = (model_out_format == OUT_MONO) ? {31'd0, lit} : {8'd0, rgb};
            OP_MONO:
                if (lit && t.and_bit)
                begin
                    r.colour = {31'd0, same};
                    r.mask   = 1'b1;
                end
                else
                begin
                    r.colour = {31'd0, lit};
                    r.mask   = !t.and_bit;
                end
            default:
                // checkerboard where the cursor inverts a lit pixel
                if (lit && t.and_bit)
                    r.colour = ALPHA_OPAQUE | (same ? {8'd0, RGB_WHITE} : 32'd0);
                else
                    r.colour = {8'd0, rgb} | (t.and_bit ? 32'd0 : ALPHA_OPAQUE);
        endcase
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Transaction builders
    // ------------------------------------------------------------------------
    function automatic pixel_txn_t pixel_txn(input logic [1:0] kind, input logic [31:0] pix,
                                             input logic a, input logic c, input logic r);
        pixel_txn_t t;
        t.op        = kind;
        t.pixel     = pix;
        t.pal_index = 8'($urandom);
        t.red       = 8'($urandom);
        t.green     = 8'($urandom);
        t.blue      = 8'($urandom);
        t.and_bit   = a;
        t.col_odd   = c;
        t.row_odd   = r;
        return t;
    endfunction

    function automatic pixel_txn_t palette_write(input logic [7:0] idx, input logic [7:0] r,
                                                 input logic [7:0] g, input logic [7:0] b);
        pixel_txn_t t;
        t           = pixel_txn(OP_PAL_WR, $urandom, 1'($urandom), 1'($urandom),
                                1'($urandom));
        t.pal_index = idx;
        t.red       = r;
        t.green     = g;
        t.blue      = b;
        return t;
    endfunction

    function automatic logic [31:0] random_pixel(input logic [2:0] fmt);
        logic [31:0] depth_mask;
        logic [31:0] p;
        int          roll;
        case (fmt)
            FMT_1BPP:             depth_mask = 32'h0000_0001;
            FMT_8BPP:             depth_mask = 32'h0000_00ff;
            FMT_15BPP:            depth_mask = 32'h0000_7fff;
            FMT_16BPP:            depth_mask = 32'h0000_ffff;
            FMT_24BPP, FMT_32BPP: depth_mask = 32'h00ff_ffff;
            default:              depth_mask = 32'h0000_0000;
        endcase
        roll = $urandom_range(99, 0);
        p    = $urandom;
        if (roll < 12)
            p = '0;
        else if (roll < 24)
            p = p & ~depth_mask;
        else if (fmt == FMT_8BPP && roll < 60)
            p[7:0] = 8'($urandom_range(15, 0));   // hit the entries that get written
        return p;
    endfunction

    function automatic pixel_txn_t random_item(input logic [2:0] fmt);
        pixel_txn_t t;
        int         roll;
        int         write_share;
        t           = pixel_txn(OP_CONVERT, random_pixel(fmt), 1'($urandom), 1'($urandom),
                                1'($urandom));
        roll        = $urandom_range(99, 0);
        write_share = (fmt == FMT_8BPP) ? 30 : 12;
        if (roll < write_share)
            t.op = OP_PAL_WR;
        else if (roll < 50)
            t.op = OP_CONVERT;
        else if (roll < 75)
            t.op = OP_MONO;
        else
            t.op = OP_ALPHA;
        if ($urandom_range(1, 0) == 0)
            t.pal_index = 8'($urandom_range(15, 0));
        if ($urandom_range(9, 0) == 0)
            {t.red, t.green, t.blue} = '0;
        return t;
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------
    task automatic send_item(input pixel_txn_t t);
        colour_result_t r;
        bit             rdy;
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= t.op;
        pixel_in      <= t.pixel;
        palette_index <= t.pal_index;
        palette_red   <= t.red;
        palette_green <= t.green;
        palette_blue  <= t.blue;
        and_bit       <= t.and_bit;
        col_odd       <= t.col_odd;
        row_odd       <= t.row_odd;
        // sample ready mid-cycle, the transaction lands on the next edge
        do
        begin
            @(negedge clk);
            rdy = in_ready;
            @(posedge clk);
        end
        while (!rdy);
        op_count[t.op]++;
        if (predict_result(t, r))
            expected_results.push_back(r);
    endtask

    // Hold the sender until every pending result is back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        // palette writes leave no result, let the pipe empty
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [2:0] value);
        bit rdy;
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(negedge clk);
            rdy = cfg_ready;
            @(posedge clk);
        end
        while (!rdy);
        cfg_valid <= 1'b0;
        if (idx == CFG_IN_FORMAT)
            model_in_format = value;
        else
            model_out_format = value[0];
    endtask

    always @(posedge clk)
        out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    always
    begin : result_checker
        logic           hit;
        logic [31:0]    got_colour;
        logic           got_mask;
        colour_result_t want;
        @(negedge clk);
        hit        = (out_valid === 1'b1) && out_ready;
        got_colour = colour_out;
        got_mask   = mask_out;
        @(posedge clk);
        if (hit)
        begin
            result_count++;
            if (expected_results.size() == 0)
                note_failure($sformatf("unexpected result: colour_out %h mask_out %b",
                                       got_colour, got_mask));
            else
            begin
                want = expected_results.pop_front();
                if (got_colour !== want.colour)
                    note_failure($sformatf("colour_out mismatch, op %0d: expected %h, got %h",
                                           want.op, want.colour, got_colour));
                if (got_mask !== want.mask)
                    note_failure($sformatf("mask_out mismatch, op %0d: expected %b, got %b",
                                           want.op, want.mask, got_mask));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_reset_defaults();
        // 24 bpp RGB out of reset: byte swap, top byte dropped
        send_item(pixel_txn(OP_CONVERT, 32'h0000_0000, 1'b0, 1'b0, 1'b0));
        send_item(pixel_txn(OP_CONVERT, 32'hffff_ffff, 1'b1, 1'b1, 1'b1));
        drain_results();
    endtask

    task automatic test_palette_lookup();
        send_item(palette_write(8'd255, 8'hff, 8'hff, 8'hff));
        send_item(palette_write(8'd0, 8'h12, 8'h34, 8'h56));
        write_register(CFG_IN_FORMAT, FMT_8BPP);
        send_item(pixel_txn(OP_CONVERT, 32'hffff_ff00, 1'b0, 1'b0, 1'b0));
        send_item(pixel_txn(OP_CONVERT, 32'h0000_00ff, 1'b0, 1'b0, 1'b0));
        send_item(pixel_txn(OP_CONVERT, 32'h0000_0007, 1'b0, 1'b0, 1'b0));
        // write then read the same entry back to back
        send_item(palette_write(8'd7, 8'h0a, 8'h0b, 8'h0c));
        send_item(pixel_txn(OP_CONVERT, 32'h0000_0007, 1'b0, 1'b0, 1'b0));
        drain_results();
    endtask

    task automatic test_source_depths();
        write_register(CFG_IN_FORMAT, FMT_1BPP);
        send_item(pixel_txn(OP_CONVERT, 32'h0000_0000, 1'b0, 1'b0, 1'b0));
        send_item(pixel_txn(OP_CONVERT, 32'h8000_0000, 1'b0, 1'b0, 1'b0));
        write_register(CFG_IN_FORMAT, FMT_15BPP);
        send_item(pixel_txn(OP_CONVERT, 32'h0000_7fff, 1'b0, 1'b0, 1'b0));
        send_item(pixel_txn(OP_CONVERT, 32'hffff_8000, 1'b0, 1'b0, 1'b0));
        write_register(CFG_IN_FORMAT, FMT_16BPP);
        send_item(pixel_txn(OP_CONVERT, 32'h0000_ffff, 1'b0, 1'b0, 1'b0));
        send_item(pixel_txn(OP_CONVERT, 32'h0001_f81f, 1'b0, 1'b0, 1'b0));
        // unknown depths convert to black
        write_register(CFG_IN_FORMAT, 3'd6);
        send_item(pixel_txn(OP_CONVERT, 32'hffff_ffff, 1'b0, 1'b0, 1'b0));
        write_register(CFG_IN_FORMAT, 3'd7);
        send_item(pixel_txn(OP_ALPHA, 32'h0000_0001, 1'b0, 1'b0, 1'b0));
        drain_results();
    endtask

    task automatic test_cursor_ops();
        write_register(CFG_IN_FORMAT, FMT_32BPP);
        write_register(CFG_OUT_FORMAT, {2'b00, OUT_MONO});
        send_item(pixel_txn(OP_CONVERT, 32'h0000_0001, 1'b0, 1'b0, 1'b0));
        // mono cursor: checkerboard, plain source, transparent
        send_item(pixel_txn(OP_MONO, 32'h0000_0001, 1'b1, 1'b0, 1'b0));
        send_item(pixel_txn(OP_MONO, 32'h0000_0001, 1'b1, 1'b1, 1'b0));
        send_item(pixel_txn(OP_MONO, 32'hff00_0000, 1'b0, 1'b0, 1'b1));
        send_item(pixel_txn(OP_MONO, 32'h0080_0000, 1'b0, 1'b1, 1'b1));
        send_item(pixel_txn(OP_MONO, 32'h0000_0000, 1'b1, 1'b0, 1'b1));
        // alpha cursor: out_format must not matter here
        send_item(pixel_txn(OP_ALPHA, 32'h0012_3456, 1'b1, 1'b1, 1'b1));
        send_item(pixel_txn(OP_ALPHA, 32'h0012_3456, 1'b1, 1'b0, 1'b1));
        send_item(pixel_txn(OP_ALPHA, 32'h00ab_cdef, 1'b0, 1'b0, 1'b0));
        send_item(pixel_txn(OP_ALPHA, 32'hff00_0000, 1'b1, 1'b1, 1'b0));
        drain_results();
    endtask

    // Sweep all source depths with random traffic under one idle profile.
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input logic out_flip);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int fmt = 0; fmt < 8; fmt++)
        begin
            write_register(CFG_IN_FORMAT, fmt[2:0]);
            write_register(CFG_OUT_FORMAT, {2'b00, fmt[0] ^ out_flip});
            for (int n = 0; n < ITEMS_PER_SETTING; n++)
            begin
                if (n == ITEMS_PER_SETTING / 2)
                    drain_results();
                send_item(random_item(fmt[2:0]));
            end
        end
        drain_results();
    endtask

    initial
    begin
        for (int i = 0; i < 256; i++)
            model_palette[i] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_palette_lookup();
        test_source_depths();
        test_cursor_ops();
        test_random_traffic(7, 64, 1'b0);
        test_random_traffic(64, 7, 1'b1);
        test_random_traffic(0, 0, 1'b0);

        if (expected_results.size() != 0)
            note_failure($sformatf("%0d expected results never arrived",
                                   expected_results.size()));
        $display("Sent %0d transactions: %0d palette writes, %0d conversions,",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3],
                 op_count[OP_PAL_WR], op_count[OP_CONVERT]);
        $display("  %0d mono and %0d alpha cursor pixels over all eight in_format codes,",
                 op_count[OP_MONO], op_count[OP_ALPHA]);
        $display("  both out_formats, three idle profiles; %0d results, %0d failures",
                 result_count, error_count);
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/pcfc_pkg.sv
rtl/pcfc_palette.sv
rtl/pcfc_convert.sv
rtl/pixel_and_cursor_format_converter.sv
dv/tb_top.sv
